// ===== rtl/rds_pkg.sv =====
// Package for the RSSI diversity selector: beat types, register map,
// reset values and mode codes. No dependencies.
package rds_pkg;

  localparam int unsigned ADC_BITS   = 12;
  localparam int unsigned LEVEL_W    = 7;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned MARGIN_W   = 7;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  // (raw - low) * 100 needs ADC_BITS + 7 bits
  localparam int unsigned NUM_W      = ADC_BITS + LEVEL_W;
  localparam int unsigned QCNT_W     = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(100);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_A_CAL_LOW     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_A_CAL_HIGH    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_B_CAL_LOW     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_B_CAL_HIGH    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SELECT_MODE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SWITCH_MARGIN = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE_TICKS  = 3'd7;

  // select modes; the fourth code falls back to auto
  localparam logic [MODE_W-1:0] MODE_AUTO    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FORCE_A = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FORCE_B = 2'd2;

  localparam logic RX_A = 1'b0;
  localparam logic RX_B = 1'b1;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_TUNE = 1'b1;

  localparam logic [ADC_BITS-1:0] RST_CAL_LOW       = '0;
  localparam logic [ADC_BITS-1:0] RST_CAL_HIGH      = '1;
  localparam logic [MODE_W-1:0]   RST_SELECT_MODE   = MODE_AUTO;
  localparam logic [MARGIN_W-1:0] RST_SWITCH_MARGIN = MARGIN_W'(5);
  localparam logic [COUNT_W-1:0]  RST_HOLD_TICKS    = COUNT_W'(100);
  localparam logic [COUNT_W-1:0]  RST_SETTLE_TICKS  = COUNT_W'(25);

  typedef struct packed {
    logic                req_type;
    logic [ADC_BITS-1:0] raw_a;
    logic [ADC_BITS-1:0] raw_b;
  } rds_req_t;

  typedef struct packed {
    logic               active_rx;
    logic [LEVEL_W-1:0] level_a;
    logic [LEVEL_W-1:0] level_b;
    logic               settled;
  } rds_rsp_t;

endpackage

// ===== rtl/rds_scale.sv =====
// Serial level scaler: maps a raw sample from its low..high range to 0..100.
// One restoring-division subtractor, one quotient bit per cycle. Uses rds_pkg.
module rds_scale import rds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [ADC_BITS-1:0] raw_i,
  input  logic [ADC_BITS-1:0] low_i,
  input  logic [ADC_BITS-1:0] high_i,
  output logic                done_o,
  output logic [LEVEL_W-1:0]  level_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic [NUM_W-1:0]    rem_q, rem_d;
  logic [ADC_BITS-1:0] den_q, den_d;
  logic [LEVEL_W-1:0]  quo_q, quo_d;
  logic [LEVEL_W-1:0]  level_q, level_d;

  logic [ADC_BITS-1:0] diff;
  logic [ADC_BITS-1:0] span;
  logic [NUM_W:0]      trial;
  logic                fits;

  assign diff  = raw_i - low_i;
  assign span  = high_i - low_i;
  assign trial = {1'b0, rem_q} - ({1'b0, NUM_W'(den_q)} << cnt_q);
  assign fits  = ~trial[NUM_W];

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    level_d = level_q;
    if (busy_q) begin
      if (fits) begin
        rem_d = trial[NUM_W-1:0];
      end
      quo_d = {quo_q[LEVEL_W-2:0], fits};
      cnt_d = cnt_q - QCNT_W'(1);
      if (cnt_q == '0) begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        level_d = {quo_q[LEVEL_W-2:0], fits};
      end
    end else if (start_i) begin
      priority if (raw_i <= low_i || high_i <= low_i) begin
        level_d = '0;
        done_d  = 1'b1;
      end else if (diff >= span) begin
        // quotient would reach 100 or more: clamp
        level_d = LEVEL_FULL;
        done_d  = 1'b1;
      end else begin
        // quotient stays below 100, so seven bits cover it
        rem_d  = NUM_W'(diff) * NUM_W'(LEVEL_FULL);
        den_d  = span;
        quo_d  = '0;
        cnt_d  = QCNT_W'(LEVEL_W - 1);
        busy_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
    level_q <= level_d;
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule

// ===== rtl/rssi_diversity_selector.sv =====
// RSSI antenna diversity selector: top level with register file, sequencer
// and output register. Uses rds_pkg and rds_scale.
//
// Usage:
//   Input beats (in_valid_i/in_stall_o) are either a tick with one raw sample
//   per receiver or a tune event that restarts the settle counter. Every
//   accepted beat yields exactly one result beat (out_valid_o/out_stall_i)
//   holding the selected receiver, both last levels and the settled flag.
//   One beat is in flight at a time: in_stall_o stays high from acceptance
//   until the result is loaded into the output register.
//   A tune event or a tick before the settle time ends goes from acceptance
//   straight to the output state. A settled tick scales both samples
//   one after the other on a single restoring divider (7 quotient bits,
//   one per cycle, or a direct result when the level clamps or is zero)
//   and then runs the selection before going to the output state.
//   A new beat is taken the cycle after the result is loaded, even while
//   the receiver still stalls it; the next result then waits in the
//   sequencer until the output register frees up.
//   Reset clears the state to receiver A, zero levels and counters, and
//   loads the register defaults. The APB port is always ready; write it
//   only while no beat is in flight.
module rssi_diversity_selector import rds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rds_req_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rds_rsp_t              out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RUN_A  = 3'd1;
  localparam logic [2:0] ST_WAIT_A = 3'd2;
  localparam logic [2:0] ST_RUN_B  = 3'd3;
  localparam logic [2:0] ST_WAIT_B = 3'd4;
  localparam logic [2:0] ST_SELECT = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // configuration registers
  logic [ADC_BITS-1:0] a_cal_low_q, a_cal_high_q, b_cal_low_q, b_cal_high_q;
  logic [MODE_W-1:0]   select_mode_q;
  logic [MARGIN_W-1:0] switch_margin_q;
  logic [COUNT_W-1:0]  hold_ticks_q, settle_ticks_q;

  logic [2:0]          state_q, state_d;
  logic                current_rx_q, current_rx_d;
  logic                target_rx_q, target_rx_d;
  logic [COUNT_W-1:0]  hold_count_q, hold_count_d;
  logic [COUNT_W-1:0]  settle_count_q, settle_count_d;
  logic [LEVEL_W-1:0]  scaled_a_q, scaled_a_d;
  logic [LEVEL_W-1:0]  scaled_b_q, scaled_b_d;
  logic [ADC_BITS-1:0] raw_a_q, raw_b_q;
  logic                out_valid_q, out_valid_d;
  rds_rsp_t            out_data_q, out_data_d;

  logic                cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                in_accept;
  logic [COUNT_W-1:0]  settle_bumped;
  logic [COUNT_W-1:0]  hold_bumped;

  logic                scale_start;
  logic                scale_done;
  logic [LEVEL_W-1:0]  scale_level;
  logic [ADC_BITS-1:0] scale_raw, scale_low, scale_high;

  logic                a_gt, b_gt, best_rx;
  logic [LEVEL_W-1:0]  lead;

  assign cfg_write = psel & penable & pwrite;
  assign reg_idx   = paddr[CFG_ADDR_W-1:2];
  assign pready    = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_A_CAL_LOW:     prdata = CFG_DATA_W'(a_cal_low_q);
      REG_A_CAL_HIGH:    prdata = CFG_DATA_W'(a_cal_high_q);
      REG_B_CAL_LOW:     prdata = CFG_DATA_W'(b_cal_low_q);
      REG_B_CAL_HIGH:    prdata = CFG_DATA_W'(b_cal_high_q);
      REG_SELECT_MODE:   prdata = CFG_DATA_W'(select_mode_q);
      REG_SWITCH_MARGIN: prdata = CFG_DATA_W'(switch_margin_q);
      REG_HOLD_TICKS:    prdata = CFG_DATA_W'(hold_ticks_q);
      REG_SETTLE_TICKS:  prdata = CFG_DATA_W'(settle_ticks_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cal_low_q     <= RST_CAL_LOW;
      a_cal_high_q    <= RST_CAL_HIGH;
      b_cal_low_q     <= RST_CAL_LOW;
      b_cal_high_q    <= RST_CAL_HIGH;
      select_mode_q   <= RST_SELECT_MODE;
      switch_margin_q <= RST_SWITCH_MARGIN;
      hold_ticks_q    <= RST_HOLD_TICKS;
      settle_ticks_q  <= RST_SETTLE_TICKS;
    end else if (cfg_write && pready) begin
      unique case (reg_idx)
        REG_A_CAL_LOW:     a_cal_low_q     <= pwdata[ADC_BITS-1:0];
        REG_A_CAL_HIGH:    a_cal_high_q    <= pwdata[ADC_BITS-1:0];
        REG_B_CAL_LOW:     b_cal_low_q     <= pwdata[ADC_BITS-1:0];
        REG_B_CAL_HIGH:    b_cal_high_q    <= pwdata[ADC_BITS-1:0];
        REG_SELECT_MODE:   select_mode_q   <= pwdata[MODE_W-1:0];
        REG_SWITCH_MARGIN: switch_margin_q <= pwdata[MARGIN_W-1:0];
        REG_HOLD_TICKS:    hold_ticks_q    <= pwdata[COUNT_W-1:0];
        REG_SETTLE_TICKS:  settle_ticks_q  <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign settle_bumped = (settle_count_q == COUNT_MAX) ? COUNT_MAX
                                                       : settle_count_q + COUNT_W'(1);
  assign hold_bumped   = (hold_count_q == COUNT_MAX) ? COUNT_MAX
                                                     : hold_count_q + COUNT_W'(1);

  // shared scaler operands follow the sequencer
  assign scale_start = (state_q == ST_RUN_A) || (state_q == ST_RUN_B);
  assign scale_raw   = (state_q == ST_RUN_B) ? raw_b_q      : raw_a_q;
  assign scale_low   = (state_q == ST_RUN_B) ? b_cal_low_q  : a_cal_low_q;
  assign scale_high  = (state_q == ST_RUN_B) ? b_cal_high_q : a_cal_high_q;

  rds_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .raw_i   (scale_raw),
    .low_i   (scale_low),
    .high_i  (scale_high),
    .done_o  (scale_done),
    .level_o (scale_level)
  );

  assign a_gt    = scaled_a_q > scaled_b_q;
  assign b_gt    = scaled_b_q > scaled_a_q;
  assign best_rx = a_gt ? RX_A : (b_gt ? RX_B : current_rx_q);
  assign lead    = a_gt ? scaled_a_q - scaled_b_q
                        : (b_gt ? scaled_b_q - scaled_a_q : '0);

  always_comb begin
    state_d        = state_q;
    current_rx_d   = current_rx_q;
    target_rx_d    = target_rx_q;
    hold_count_d   = hold_count_q;
    settle_count_d = settle_count_q;
    scaled_a_d     = scaled_a_q;
    scaled_b_d     = scaled_b_q;
    out_data_d     = out_data_q;
    out_valid_d    = out_valid_q & out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data_i.req_type == REQ_TUNE) begin
            settle_count_d = '0;
            state_d        = ST_OUT;
          end else begin
            settle_count_d = settle_bumped;
            hold_count_d   = hold_bumped;
            state_d        = (settle_bumped >= settle_ticks_q) ? ST_RUN_A : ST_OUT;
          end
        end
      end
      ST_RUN_A: state_d = ST_WAIT_A;
      ST_WAIT_A: begin
        if (scale_done) begin
          scaled_a_d = scale_level;
          state_d    = ST_RUN_B;
        end
      end
      ST_RUN_B: state_d = ST_WAIT_B;
      ST_WAIT_B: begin
        if (scale_done) begin
          scaled_b_d = scale_level;
          state_d    = ST_SELECT;
        end
      end
      ST_SELECT: begin
        priority if (select_mode_q == MODE_FORCE_A) begin
          current_rx_d = RX_A;
        end else if (select_mode_q == MODE_FORCE_B) begin
          current_rx_d = RX_B;
        end else if (lead >= switch_margin_q) begin
          if (best_rx == target_rx_q) begin
            if (hold_count_q >= hold_ticks_q) begin
              current_rx_d = target_rx_q;
            end
          end else begin
            target_rx_d  = best_rx;
            hold_count_d = '0;
          end
        end else begin
          // lead too small: restart the hold
          hold_count_d = '0;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register frees up
        if (!out_valid_q || !out_stall_i) begin
          out_data_d.active_rx = current_rx_q;
          out_data_d.level_a   = scaled_a_q;
          out_data_d.level_b   = scaled_b_q;
          out_data_d.settled   = (settle_count_q >= settle_ticks_q);
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      current_rx_q   <= RX_A;
      target_rx_q    <= RX_A;
      hold_count_q   <= '0;
      settle_count_q <= '0;
      scaled_a_q     <= '0;
      scaled_b_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      current_rx_q   <= current_rx_d;
      target_rx_q    <= target_rx_d;
      hold_count_q   <= hold_count_d;
      settle_count_q <= settle_count_d;
      scaled_a_q     <= scaled_a_d;
      scaled_b_q     <= scaled_b_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_accept) begin
      raw_a_q <= in_data_i.raw_a;
      raw_b_q <= in_data_i.raw_b;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/rds_checker.sv =====
// Port-level checks for the RSSI diversity selector, bound to the top level.
// Uses rds_pkg.
module rds_checker import rds_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input rds_rsp_t out_data_o
);

  // a stalled result beat stays and does not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed under stall");

  // an accepted beat keeps the input stalled while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a beat");

  // a new result only appears while a beat was in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without a beat in flight");

  // levels never exceed full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.level_a <= LEVEL_FULL) &&
                    (out_data_o.level_b <= LEVEL_FULL))
    else $error("level above 100 percent");

endmodule

bind rssi_diversity_selector rds_checker u_rds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
